@@ design/psd_pkg.sv @@
// types and helpers shared by the pair sorter cells and top level
// no dependencies
`timescale 1ns / 1ps

package psd_pkg;

  localparam int KEY_WIDTH = 32;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] primary_key;
    logic signed [KEY_WIDTH-1:0] secondary_key;
    logic                        batch_end;
  } psd_in_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] out_primary;
    logic signed [KEY_WIDTH-1:0] out_secondary;
    logic                        final_pair;
    logic                        overflowed;
  } psd_out_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] first;
    logic signed [KEY_WIDTH-1:0] second;
  } pair_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic valid;
    logic slot;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // x must come before y: ascending first key, descending second key
  function automatic logic goes_before(input pair_t x, input pair_t y);
    logic lt_first;
    logic eq_first;
    logic gt_second;
    lt_first  = $signed(x.first) < $signed(y.first);
    eq_first  = x.first == y.first;
    gt_second = $signed(x.second) > $signed(y.second);
    return lt_first | (eq_first & gt_second);
  endfunction

endpackage

@@ design/psd_cell.sv @@
// one cell of the sorting chain: holds one pair, inserts or shifts
// depends on psd_pkg
`timescale 1ns / 1ps

module psd_cell (
  input  logic               clk,
  input  psd_pkg::cell_ctrl_t ctrl,
  input  psd_pkg::pair_t     new_pair,
  input  psd_pkg::pair_t     prev_pair,
  input  logic               prev_bump,
  input  psd_pkg::pair_t     next_pair,
  output psd_pkg::pair_t     pair,
  output logic               bump
);
  import psd_pkg::*;

  assign bump = ctrl.valid & goes_before(new_pair, pair);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (prev_bump) begin
        pair <= prev_pair;
      end else if (bump || ctrl.slot) begin
        pair <= new_pair;
      end
    end else if (ctrl.shift) begin
      pair <= next_pair;
    end
  end

endmodule

@@ design/pair_sort_asc_first_desc_second.sv @@
// top level of the pair sorter: insertion chain of cells plus drain control
// depends on psd_pkg and psd_cell
//
//   channel   ports                      handshake
//   request   start, busy, request       taken when start & !busy
//   result    strobe, result             strobe marks each result, no stall
//
// one pair is taken per cycle while busy is low; insertion is done by
// all cells in parallel in that cycle
// after a batch_end request, busy stays high until every stored pair is out,
// while the chain shifts toward cell 0, one result per cycle
// synchronous reset empties the store and clears the overflow flag
`timescale 1ns / 1ps

module pair_sort_asc_first_desc_second #(
  parameter int CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psd_pkg::psd_in_t  request,
  output logic              strobe,
  output psd_pkg::psd_out_t result
);
  import psd_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            overflow;
  logic            overflow_next;
  logic            accept;
  logic            do_insert;
  logic            do_shift;
  pair_t           new_pair;
  pair_t           cell_pair [CAPACITY];
  logic            cell_bump [CAPACITY];
  cell_ctrl_t      ctrl      [CAPACITY];

  assign busy      = state == ST_DRAIN;
  assign accept    = start & ~busy;
  assign do_insert = accept & (count != CW'(CAPACITY));
  assign do_shift  = busy;
  assign new_pair  = '{first: request.primary_key, second: request.secondary_key};

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (do_insert) begin
            count_next = count + CW'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (request.batch_end) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        count_next = count - CW'(1);
        if (count == CW'(1)) begin
          state_next    = ST_IDLE;
          overflow_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
      strobe   <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      result.out_primary   <= cell_pair[0].first;
      result.out_secondary <= cell_pair[0].second;
      result.final_pair    <= count == CW'(1);
      result.overflowed    <= overflow;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctrl[i].insert = do_insert;
    assign ctrl[i].shift  = do_shift;
    assign ctrl[i].valid  = count > CW'(i);
    assign ctrl[i].slot   = count == CW'(i);

    psd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .new_pair  (new_pair),
      .prev_pair (cell_pair[(i == 0) ? 0 : i - 1]),
      .prev_bump ((i == 0) ? 1'b0 : cell_bump[(i == 0) ? 0 : i - 1]),
      .next_pair (cell_pair[(i == CAPACITY - 1) ? i : i + 1]),
      .pair      (cell_pair[i]),
      .bump      (cell_bump[i])
    );
  end

`ifndef SYNTH
  a_strobe_after_drain: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_DRAIN))
    else $error("result strobe without drain cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("drain with empty store");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (busy && count == CW'(1)) |=> (strobe && result.final_pair && !busy && count == '0))
    else $error("last result does not end the batch");
`endif

endmodule
